// ===== hw/rtl/irlf_pkg.sv =====
package irlf_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned LIMIT_W = 16;
    localparam int unsigned DEPTH_W = 16;
    localparam int unsigned LIT_W   = 32;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'd9999;

    localparam logic [BYTE_W-1:0] CH_LBRACE = 8'h7B;
    localparam logic [BYTE_W-1:0] CH_RBRACE = 8'h7D;
    localparam logic [BYTE_W-1:0] CH_QUOTE  = 8'h22;
    localparam logic [BYTE_W-1:0] CH_BSLASH = 8'h5C;
    localparam logic [BYTE_W-1:0] CH_LPAREN = 8'h28;
    localparam logic [BYTE_W-1:0] CH_RPAREN = 8'h29;
    localparam logic [BYTE_W-1:0] CH_LF     = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_CR     = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_ZERO   = 8'h30;

    localparam logic signed [DEPTH_W-1:0] DEPTH_MAX = 16'sh7FFF;
    localparam logic signed [DEPTH_W-1:0] DEPTH_MIN = 16'sh8000;

    typedef struct packed {
        logic [BYTE_W-1:0] first_byte;
        logic [BYTE_W-1:0] second_byte;
        logic              two;
        logic              line_end;
    } result_t;

endpackage

// ===== hw/rtl/imap_response_line_framer_core.sv =====
// Response line framer: takes one byte of a response stream per beat and emits
// the framed line bytes. A new byte can be accepted in every cycle while the
// output keeps up; a byte that completes a literal produces two output beats
// (the byte and a closing quote), so it holds the input until both are taken,
// and header and dropped bytes produce none. The per-line state is updated as
// a byte moves from the input register to the result register, from which the
// first beat of a result is offered. tlast marks the beat that ends a line,
// tuser the last beat caused by one input byte. line_limit is to be written
// through cfg_* only while the block is idle; the block itself does not
// enforce this. line_limit resets to 9999.
module imap_response_line_framer_core
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [irlf_pkg::BYTE_W-1:0]   s_tdata,   // [7:0] in_byte
    input  logic                          s_tuser,   // [0] balanced_request
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [irlf_pkg::BYTE_W-1:0]   m_tdata,   // [7:0] out_byte
    output logic                          m_tlast,
    output logic                          m_tuser,   // [0] run_last
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [irlf_pkg::LIMIT_W-1:0]  cfg_data
);

    logic [irlf_pkg::LIMIT_W-1:0] limit_reg;
    logic                         item_valid;
    logic [irlf_pkg::BYTE_W-1:0]  item_byte;
    logic                         item_bal;
    logic                         has_result;
    logic                         slot_free;
    logic                         advance;
    irlf_pkg::result_t            result;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= irlf_pkg::LIMIT_RESET;
        end
        else if (cfg_valid)
        begin
            limit_reg <= cfg_data;
        end
    end

    assign advance = item_valid && (!has_result || slot_free);

    irlf_in_reg u_in_reg
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .advance    (advance),
        .item_valid (item_valid),
        .item_byte  (item_byte),
        .item_bal   (item_bal)
    );

    irlf_engine u_engine
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_byte  (item_byte),
        .item_bal   (item_bal),
        .line_limit (limit_reg),
        .advance    (advance),
        .has_result (has_result),
        .result     (result)
    );

    irlf_out_buf u_out_buf
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (advance && has_result),
        .result    (result),
        .slot_free (slot_free),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

endmodule

// ===== hw/rtl/irlf_in_reg.sv =====
module irlf_in_reg
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [irlf_pkg::BYTE_W-1:0]  s_tdata,
    input  logic                         s_tuser,
    input  logic                         advance,
    output logic                         item_valid,
    output logic [irlf_pkg::BYTE_W-1:0]  item_byte,
    output logic                         item_bal
);

    logic                        valid_reg;
    logic                        valid_next;
    logic [irlf_pkg::BYTE_W-1:0] byte_reg;
    logic                        bal_reg;
    logic                        load;

    assign s_tready = !valid_reg || advance;
    assign load     = s_tvalid && s_tready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg <= s_tdata;
            bal_reg  <= s_tuser;
        end
    end

    assign item_valid = valid_reg;
    assign item_byte  = byte_reg;
    assign item_bal   = bal_reg;

endmodule

// ===== hw/rtl/irlf_engine.sv =====
module irlf_engine
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [irlf_pkg::BYTE_W-1:0]   item_byte,
    input  logic                          item_bal,
    input  logic [irlf_pkg::LIMIT_W-1:0]  line_limit,
    input  logic                          advance,
    output logic                          has_result,
    output irlf_pkg::result_t             result
);

    logic signed [irlf_pkg::DEPTH_W-1:0] depth_reg;
    logic signed [irlf_pkg::DEPTH_W-1:0] depth_next;
    logic                                quote_reg;
    logic                                quote_next;
    logic                                esc_reg;
    logic                                esc_next;
    logic                                hdr_reg;
    logic                                hdr_next;
    logic [irlf_pkg::LIT_W-1:0]          lit_reg;
    logic [irlf_pkg::LIT_W-1:0]          lit_next;
    logic [irlf_pkg::LIMIT_W-1:0]        count_reg;
    logic [irlf_pkg::LIMIT_W-1:0]        count_next;

    logic                                emit;
    logic                                two;
    logic                                nl_end;
    logic                                end_line;
    logic [irlf_pkg::BYTE_W-1:0]         first_byte;
    logic [irlf_pkg::LIMIT_W:0]          count_sum;

    always_comb
    begin
        depth_next = depth_reg;
        quote_next = quote_reg;
        esc_next   = esc_reg;
        hdr_next   = hdr_reg;
        lit_next   = lit_reg;
        count_next = count_reg;
        emit       = 1'b1;
        two        = 1'b0;
        nl_end     = 1'b0;
        first_byte = item_byte;

        if (hdr_reg)
        begin
            emit = 1'b0;
            if (item_byte == irlf_pkg::CH_RBRACE)
            begin
                hdr_next = 1'b0;
            end
            else
            begin
                lit_next = (lit_reg << 3) + (lit_reg << 1)
                         + {{(irlf_pkg::LIT_W-irlf_pkg::BYTE_W){1'b0}}, item_byte}
                         - {{(irlf_pkg::LIT_W-irlf_pkg::BYTE_W){1'b0}}, irlf_pkg::CH_ZERO};
            end
        end
        else if (lit_reg != '0)
        begin
            if (item_byte == irlf_pkg::CH_LF || item_byte == irlf_pkg::CH_CR)
            begin
                emit = 1'b0;
            end
            else
            begin
                lit_next = lit_reg - {{(irlf_pkg::LIT_W-1){1'b0}}, 1'b1};
                two      = (lit_reg == {{(irlf_pkg::LIT_W-1){1'b0}}, 1'b1});
            end
        end
        else if (esc_reg)
        begin
            esc_next = 1'b0;
        end
        else
        begin
            case (item_byte)
                irlf_pkg::CH_BSLASH:
                begin
                    esc_next = 1'b1;
                end
                irlf_pkg::CH_LPAREN:
                begin
                    if (!quote_reg && depth_reg != irlf_pkg::DEPTH_MAX)
                    begin
                        depth_next = depth_reg + 16'sd1;
                    end
                end
                irlf_pkg::CH_RPAREN:
                begin
                    if (!quote_reg && depth_reg != irlf_pkg::DEPTH_MIN)
                    begin
                        depth_next = depth_reg - 16'sd1;
                    end
                end
                irlf_pkg::CH_QUOTE:
                begin
                    quote_next = !quote_reg;
                end
                irlf_pkg::CH_LBRACE:
                begin
                    if (item_bal && !quote_reg)
                    begin
                        hdr_next   = 1'b1;
                        lit_next   = '0;
                        first_byte = irlf_pkg::CH_QUOTE;
                    end
                end
                irlf_pkg::CH_LF:
                begin
                    nl_end = !item_bal || (depth_reg <= 16'sd0 && !quote_reg);
                end
                default:
                begin
                end
            endcase
        end

        count_sum = {1'b0, count_reg} + (two ? 17'd2 : 17'd1);
        end_line  = nl_end || (count_sum >= {1'b0, line_limit});

        if (emit)
        begin
            if (end_line)
            begin
                depth_next = '0;
                quote_next = 1'b0;
                esc_next   = 1'b0;
                hdr_next   = 1'b0;
                lit_next   = '0;
                count_next = '0;
            end
            else
            begin
                count_next = count_sum[irlf_pkg::LIMIT_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_reg <= '0;
            quote_reg <= 1'b0;
            esc_reg   <= 1'b0;
            hdr_reg   <= 1'b0;
            lit_reg   <= '0;
            count_reg <= '0;
        end
        else if (advance)
        begin
            depth_reg <= depth_next;
            quote_reg <= quote_next;
            esc_reg   <= esc_next;
            hdr_reg   <= hdr_next;
            lit_reg   <= lit_next;
            count_reg <= count_next;
        end
    end

    assign has_result         = emit;
    assign result.first_byte  = first_byte;
    assign result.second_byte = irlf_pkg::CH_QUOTE;
    assign result.two         = two;
    assign result.line_end    = end_line;

endmodule

// ===== hw/rtl/irlf_out_buf.sv =====
module irlf_out_buf
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         load,
    input  irlf_pkg::result_t            result,
    output logic                         slot_free,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [irlf_pkg::BYTE_W-1:0]  m_tdata,
    output logic                         m_tlast,
    output logic                         m_tuser
);

    logic              valid_reg;
    logic              valid_next;
    logic              phase_reg;
    logic              phase_next;
    irlf_pkg::result_t res_reg;
    logic              last_beat;

    assign last_beat = !res_reg.two || phase_reg;
    assign slot_free = !valid_reg || (m_tready && last_beat);

    always_comb
    begin
        valid_next = valid_reg;
        phase_next = phase_reg;
        if (load)
        begin
            valid_next = 1'b1;
            phase_next = 1'b0;
        end
        else if (valid_reg && m_tready)
        begin
            if (last_beat)
            begin
                valid_next = 1'b0;
            end
            else
            begin
                phase_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            phase_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= result;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = phase_reg ? res_reg.second_byte : res_reg.first_byte;
    assign m_tlast  = res_reg.line_end && last_beat;
    assign m_tuser  = last_beat;

endmodule

// ===== hw/rtl/irlf_checker.sv =====
module irlf_checker
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         m_tvalid,
    input  logic                         m_tready,
    input  logic [irlf_pkg::BYTE_W-1:0]  m_tdata,
    input  logic                         m_tlast,
    input  logic                         m_tuser
);

    // The first beat of a pair never ends the line.
    a_first_not_end: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> !m_tlast)
        else $error("line end on first beat of a pair");

    // The second beat of a pair follows at once and is the closing quote.
    a_pair_follows: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && !m_tuser |=> m_tvalid && m_tuser
            && m_tdata == irlf_pkg::CH_QUOTE)
        else $error("second beat of a pair missing");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output beat dropped or changed while stalled");

endmodule

bind imap_response_line_framer_core irlf_checker u_irlf_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);
